/* rtl/core/spike_detect_peak_align_macros.svh */
// ---------------------------------------------------------------------------
// Spike detector assertion macros
// Shared concurrent assertion forms. They expand to nothing when SYNTHESIS
// is defined.
// ---------------------------------------------------------------------------
`ifndef SPIKE_DETECT_PEAK_ALIGN_MACROS_SVH
`define SPIKE_DETECT_PEAK_ALIGN_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define SDPA_ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sdpa: implication check failed");
// Next-cycle implication
`define SDPA_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sdpa: next-cycle check failed");
`else
`define SDPA_ASSERT_IMPLIES(name, clk, rst, ante, cons)
`define SDPA_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

/* rtl/core/sdpa_pkg.sv */
// ---------------------------------------------------------------------------
// Spike detector package
// Default sizes and the sequencer state type.
// ---------------------------------------------------------------------------
`default_nettype none

package sdpa_pkg;

   localparam int WINDOW_LENGTH_DEFAULT = 16;
   localparam int END_OFFSET_DEFAULT    = 8;
   localparam int BUFFER_DEPTH_DEFAULT  = 4096;
   localparam int SAMPLE_WIDTH_DEFAULT  = 16;

   localparam int THRESHOLD_WIDTH = 16;
   localparam int POSITION_WIDTH  = 32;

   // sequencer states, one-hot
   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_ALIGN  = 5'b00100,
      ST_WRAP   = 5'b01000,
      ST_OUTPUT = 5'b10000
   } sdpa_state_type;

endpackage

`default_nettype wire

/* rtl/core/sdpa_cell.sv */
// ---------------------------------------------------------------------------
// Spike detector window cell
// Holds one window sample and passes a running (minimum, age) pair to the
// next cell every cycle. Strict less-than keeps the newer sample on ties.
// ---------------------------------------------------------------------------
`default_nettype none

module sdpa_cell #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int AGE_WIDTH    = 4,
   parameter int CELL_INDEX   = 0
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           shift_en,
   input  wire logic signed [SAMPLE_WIDTH-1:0] sample_in,
   output logic signed      [SAMPLE_WIDTH-1:0] sample_out,
   input  wire logic signed [SAMPLE_WIDTH-1:0] carry_min_in,
   input  wire logic        [AGE_WIDTH-1:0]    carry_age_in,
   output logic signed      [SAMPLE_WIDTH-1:0] carry_min_out,
   output logic             [AGE_WIDTH-1:0]    carry_age_out
);

   logic signed [SAMPLE_WIDTH-1:0] sample_ff;
   logic signed [SAMPLE_WIDTH-1:0] carry_min_ff, carry_min_in_sel;
   logic        [AGE_WIDTH-1:0]    carry_age_ff, carry_age_in_sel;

   // window sample, zero after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
      end else if (shift_en) begin
         sample_ff <= sample_in;
      end
   end

   // running minimum step
   always_comb begin
      if (sample_ff < carry_min_in) begin
         carry_min_in_sel = sample_ff;
         carry_age_in_sel = AGE_WIDTH'(CELL_INDEX);
      end else begin
         carry_min_in_sel = carry_min_in;
         carry_age_in_sel = carry_age_in;
      end
   end

   always_ff @(posedge clock) begin
      carry_min_ff <= carry_min_in_sel;
      carry_age_ff <= carry_age_in_sel;
   end

   assign sample_out    = sample_ff;
   assign carry_min_out = carry_min_ff;
   assign carry_age_out = carry_age_ff;

endmodule

`default_nettype wire

/* rtl/core/sdpa_ctrl.sv */
// ---------------------------------------------------------------------------
// Spike detector control
// Threshold register, spike flags, sample numbering, scan sequencing, peak
// position and ring index arithmetic, and the result register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "spike_detect_peak_align_macros.svh"

module sdpa_ctrl #(
   parameter int WINDOW_LENGTH = sdpa_pkg::WINDOW_LENGTH_DEFAULT,
   parameter int END_OFFSET    = sdpa_pkg::END_OFFSET_DEFAULT,
   parameter int BUFFER_DEPTH  = sdpa_pkg::BUFFER_DEPTH_DEFAULT,
   parameter int SAMPLE_WIDTH  = sdpa_pkg::SAMPLE_WIDTH_DEFAULT,
   parameter int AGE_WIDTH     = $clog2(WINDOW_LENGTH),
   parameter int RING_WIDTH    = $clog2(BUFFER_DEPTH)
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   // sample channel
   input  wire logic                                     req_valid,
   output logic                                          req_stall,
   input  wire logic signed [SAMPLE_WIDTH-1:0]           req_sample,
   // threshold register write
   input  wire logic                                     csr_valid,
   output logic                                          csr_ready,
   input  wire logic signed [sdpa_pkg::THRESHOLD_WIDTH-1:0] csr_amplitude_threshold,
   // result channel
   output logic                                          rsp_valid,
   input  wire logic                                     rsp_stall,
   output logic [sdpa_pkg::POSITION_WIDTH-1:0]           rsp_peak_position,
   output logic signed [SAMPLE_WIDTH-1:0]                rsp_peak_amplitude,
   output logic [RING_WIDTH-1:0]                         rsp_end_index,
   // cell chain
   output logic                                          shift_en,
   input  wire logic signed [SAMPLE_WIDTH-1:0]           scan_min,
   input  wire logic        [AGE_WIDTH-1:0]              scan_age
);

   import sdpa_pkg::*;

   localparam int CMP_WIDTH = (SAMPLE_WIDTH > THRESHOLD_WIDTH) ? SAMPLE_WIDTH
                                                              : THRESHOLD_WIDTH;
   localparam int LEN_WIDTH = $clog2(WINDOW_LENGTH + 2);

   sdpa_state_type state_ff, state_in;

   logic signed [THRESHOLD_WIDTH-1:0] thr_ff, thr_in;
   logic                              spike_on_ff, spike_on_in;
   logic                              blocked_ff, blocked_in;
   logic [LEN_WIDTH-1:0]              len_ff, len_in;
   logic [POSITION_WIDTH-1:0]         count_ff, count_in;
   logic [RING_WIDTH-1:0]             ring_ff, ring_in;
   logic [POSITION_WIDTH-1:0]         item_pos_ff, item_pos_in;
   logic [RING_WIDTH-1:0]             item_ring_ff, item_ring_in;
   logic [AGE_WIDTH-1:0]              scan_cnt_ff, scan_cnt_in;
   logic [RING_WIDTH-1:0]             ring_pos_ff, ring_pos_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [POSITION_WIDTH-1:0]         pos_ff, pos_in;
   logic signed [SAMPLE_WIDTH-1:0]    amp_ff, amp_in;
   logic [RING_WIDTH-1:0]             end_idx_ff, end_idx_in;

   logic                              req_beat;
   logic signed [CMP_WIDTH-1:0]       sample_ext, thr_ext;
   logic                              below, above;
   logic                              spike_end;
   logic                              spike_in_a, blocked_a;
   logic [LEN_WIDTH-1:0]              len_a;
   logic [RING_WIDTH:0]               ring_sub, ring_add;

   assign req_beat  = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign shift_en  = req_beat;
   assign csr_ready = 1'b1;

   // threshold register
   always_comb begin
      thr_in = thr_ff;
      if (csr_valid && csr_ready) begin
         thr_in = csr_amplitude_threshold;
      end
   end

   // spike detection decision for the incoming sample
   assign sample_ext = CMP_WIDTH'(req_sample);
   assign thr_ext    = CMP_WIDTH'(thr_ff);
   assign below      = (sample_ext < thr_ext);
   assign above      = (sample_ext > thr_ext);

   always_comb begin
      spike_in_a = spike_on_ff;
      blocked_a  = blocked_ff;
      len_a      = len_ff;
      spike_end  = 1'b0;
      if (thr_ff != '0) begin
         if (below && !blocked_ff && !spike_on_ff) begin
            spike_in_a = 1'b1;
         end
         // overlong spike: drop and block
         if (spike_in_a) begin
            len_a = len_ff + LEN_WIDTH'(1);
            if (len_a > LEN_WIDTH'(WINDOW_LENGTH)) begin
               len_a      = '0;
               spike_in_a = 1'b0;
               blocked_a  = 1'b1;
            end
         end
         if (above && blocked_a) begin
            blocked_a = 1'b0;
         end
         if (above && spike_in_a) begin
            spike_in_a = 1'b0;
            len_a      = '0;
            spike_end  = 1'b1;
         end
      end
   end

   // flags and sample numbering update on each input beat
   always_comb begin
      spike_on_in  = spike_on_ff;
      blocked_in   = blocked_ff;
      len_in       = len_ff;
      count_in     = count_ff;
      ring_in      = ring_ff;
      item_pos_in  = item_pos_ff;
      item_ring_in = item_ring_ff;
      if (req_beat) begin
         spike_on_in  = spike_in_a;
         blocked_in   = blocked_a;
         len_in       = len_a;
         count_in     = count_ff + POSITION_WIDTH'(1);
         ring_in      = (ring_ff == RING_WIDTH'(BUFFER_DEPTH - 1)) ? '0
                                                                  : ring_ff + RING_WIDTH'(1);
         item_pos_in  = count_ff;
         item_ring_in = ring_ff;
      end
   end

   // ring index arithmetic, one compare and subtract per stage
   assign ring_sub = (item_ring_ff >= RING_WIDTH'(scan_age))
                   ? {1'b0, item_ring_ff} - (RING_WIDTH + 1)'(scan_age)
                   : {1'b0, item_ring_ff} + (RING_WIDTH + 1)'(BUFFER_DEPTH)
                     - (RING_WIDTH + 1)'(scan_age);
   assign ring_add = {1'b0, ring_pos_ff} + (RING_WIDTH + 1)'(END_OFFSET);

   // sequencer and result register
   always_comb begin
      state_in     = state_ff;
      scan_cnt_in  = scan_cnt_ff;
      ring_pos_in  = ring_pos_ff;
      pos_in       = pos_ff;
      amp_in       = amp_ff;
      end_idx_in   = end_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      case (state_ff)
         ST_IDLE: begin
            scan_cnt_in = '0;
            if (req_beat && spike_end) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // one cell per cycle along the chain
            scan_cnt_in = scan_cnt_ff + AGE_WIDTH'(1);
            if (scan_cnt_ff == AGE_WIDTH'(WINDOW_LENGTH - 1)) begin
               state_in = ST_ALIGN;
            end
         end
         ST_ALIGN: begin
            pos_in      = item_pos_ff - POSITION_WIDTH'(scan_age);
            amp_in      = scan_min;
            ring_pos_in = RING_WIDTH'(ring_sub);
            state_in    = ST_WRAP;
         end
         ST_WRAP: begin
            if (ring_add >= (RING_WIDTH + 1)'(BUFFER_DEPTH)) begin
               end_idx_in = RING_WIDTH'(ring_add - (RING_WIDTH + 1)'(BUFFER_DEPTH));
            end else begin
               end_idx_in = RING_WIDTH'(ring_add);
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_OUTPUT;
         end
         ST_OUTPUT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         thr_ff       <= '0;
         spike_on_ff  <= 1'b0;
         blocked_ff   <= 1'b0;
         len_ff       <= '0;
         count_ff     <= '0;
         ring_ff      <= '0;
         scan_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thr_ff       <= thr_in;
         spike_on_ff  <= spike_on_in;
         blocked_ff   <= blocked_in;
         len_ff       <= len_in;
         count_ff     <= count_in;
         ring_ff      <= ring_in;
         scan_cnt_ff  <= scan_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_pos_ff  <= item_pos_in;
      item_ring_ff <= item_ring_in;
      ring_pos_ff  <= ring_pos_in;
      pos_ff       <= pos_in;
      amp_ff       <= amp_in;
      end_idx_ff   <= end_idx_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_peak_position  = pos_ff;
   assign rsp_peak_amplitude = amp_ff;
   assign rsp_end_index      = end_idx_ff;

   // checks
   `SDPA_ASSERT_IMPLIES(a_rsp_in_output, clock, reset, rsp_valid, state_ff == ST_OUTPUT)
   `SDPA_ASSERT_IMPLIES(a_flags_exclusive, clock, reset, spike_on_ff, !blocked_ff)
   `SDPA_ASSERT_IMPLIES(a_len_bound, clock, reset, 1'b1,
                        len_ff <= LEN_WIDTH'(WINDOW_LENGTH))
   `SDPA_ASSERT_NEXT(a_beat_to_idle, clock, reset, rsp_valid && !rsp_stall,
                     state_ff == ST_IDLE && !rsp_valid)
   `SDPA_ASSERT_IMPLIES(a_len_idle, clock, reset, !spike_on_ff, len_ff == '0)

endmodule

`default_nettype wire

/* rtl/core/spike_detect_peak_align.sv */
// ---------------------------------------------------------------------------
// Threshold spike detector with peak alignment
// One channel: flags spikes below a nonzero threshold and, at spike end,
// reports the window minimum, its sample number and ring index + END_OFFSET.
// ---------------------------------------------------------------------------
//
//   Channel  Direction  Handshake               Beat
//   req_     in         req_valid / req_stall   req_sample
//   rsp_     out        rsp_valid / rsp_stall   rsp_peak_position,
//                                               rsp_peak_amplitude,
//                                               rsp_end_index
//   csr_     in         csr_valid / csr_ready   csr_amplitude_threshold
//
// A sample that does not end a spike leaves req_stall low, so the next may
// follow in the next cycle. On a spike end the minimum search walks the
// cell chain one cell per cycle (SCAN), then the peak position and ring
// index are computed (ALIGN, WRAP) and registered; req_stall stays high
// until the result beat is taken.
// Reset (synchronous) clears the window to zero, the flags, the sample
// number and the threshold, which disables detection.
// ---------------------------------------------------------------------------
`default_nettype none

module spike_detect_peak_align #(
   parameter int WINDOW_LENGTH = sdpa_pkg::WINDOW_LENGTH_DEFAULT,
   parameter int END_OFFSET    = sdpa_pkg::END_OFFSET_DEFAULT,
   parameter int BUFFER_DEPTH  = sdpa_pkg::BUFFER_DEPTH_DEFAULT,
   parameter int SAMPLE_WIDTH  = sdpa_pkg::SAMPLE_WIDTH_DEFAULT
) (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  wire logic                                        req_valid,
   output logic                                             req_stall,
   input  wire logic signed [SAMPLE_WIDTH-1:0]              req_sample,
   input  wire logic                                        csr_valid,
   output logic                                             csr_ready,
   input  wire logic signed [sdpa_pkg::THRESHOLD_WIDTH-1:0] csr_amplitude_threshold,
   output logic                                             rsp_valid,
   input  wire logic                                        rsp_stall,
   output logic [sdpa_pkg::POSITION_WIDTH-1:0]              rsp_peak_position,
   output logic signed [SAMPLE_WIDTH-1:0]                   rsp_peak_amplitude,
   output logic [$clog2(BUFFER_DEPTH)-1:0]                  rsp_end_index
);

   import sdpa_pkg::*;

   localparam int AGE_WIDTH  = $clog2(WINDOW_LENGTH);
   localparam int RING_WIDTH = $clog2(BUFFER_DEPTH);

   logic                           shift_en;
   logic signed [SAMPLE_WIDTH-1:0] sample_chain [0:WINDOW_LENGTH-1];
   logic signed [SAMPLE_WIDTH-1:0] min_chain    [0:WINDOW_LENGTH];
   logic        [AGE_WIDTH-1:0]    age_chain    [0:WINDOW_LENGTH];

   // chain head: newest sample enters, search seed is the largest value
   assign sample_chain[0] = req_sample;
   assign min_chain[0]    = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
   assign age_chain[0]    = '0;

   // window cells, newest at index 0
   for (genvar i = 0; i < WINDOW_LENGTH; i++) begin : g_cell
      if (i == WINDOW_LENGTH - 1) begin : g_last
         sdpa_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .AGE_WIDTH    (AGE_WIDTH),
            .CELL_INDEX   (i)
         ) u_cell (
            .clock         (clock),
            .reset         (reset),
            .shift_en      (shift_en),
            .sample_in     (sample_chain[i]),
            .sample_out    (),
            .carry_min_in  (min_chain[i]),
            .carry_age_in  (age_chain[i]),
            .carry_min_out (min_chain[i+1]),
            .carry_age_out (age_chain[i+1])
         );
      end else begin : g_mid
         sdpa_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .AGE_WIDTH    (AGE_WIDTH),
            .CELL_INDEX   (i)
         ) u_cell (
            .clock         (clock),
            .reset         (reset),
            .shift_en      (shift_en),
            .sample_in     (sample_chain[i]),
            .sample_out    (sample_chain[i+1]),
            .carry_min_in  (min_chain[i]),
            .carry_age_in  (age_chain[i]),
            .carry_min_out (min_chain[i+1]),
            .carry_age_out (age_chain[i+1])
         );
      end
   end

   sdpa_ctrl #(
      .WINDOW_LENGTH (WINDOW_LENGTH),
      .END_OFFSET    (END_OFFSET),
      .BUFFER_DEPTH  (BUFFER_DEPTH),
      .SAMPLE_WIDTH  (SAMPLE_WIDTH),
      .AGE_WIDTH     (AGE_WIDTH),
      .RING_WIDTH    (RING_WIDTH)
   ) u_ctrl (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_sample              (req_sample),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_amplitude_threshold (csr_amplitude_threshold),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_peak_position       (rsp_peak_position),
      .rsp_peak_amplitude      (rsp_peak_amplitude),
      .rsp_end_index           (rsp_end_index),
      .shift_en                (shift_en),
      .scan_min                (min_chain[WINDOW_LENGTH]),
      .scan_age                (age_chain[WINDOW_LENGTH])
   );

endmodule

`default_nettype wire

/* test/spike_detect_peak_align_tb.sv */
// ---------------------------------------------------------------------------
// Spike detector with peak alignment: self-checking testbench
// Feeds samples through the req_ channel under several thresholds and checks
// every peak report on the rsp_ channel against a cycle-free predictor of the
// detector. Both sides idle at random, including one long result hold-off.
// ---------------------------------------------------------------------------
`default_nettype none

module spike_detect_peak_align_tb;

   import sdpa_pkg::*;

   localparam int WIN       = WINDOW_LENGTH_DEFAULT;
   localparam int OFFSET    = END_OFFSET_DEFAULT;
   localparam int DEPTH     = BUFFER_DEPTH_DEFAULT;
   localparam int SAMPLE_W  = SAMPLE_WIDTH_DEFAULT;
   localparam int INDEX_W   = $clog2(DEPTH);
   localparam int SETTLE    = WIN + 8;     // idle margin after draining
   localparam int HOLD_OFF  = 400;         // long result hold-off
   localparam int STUCK_MAX = 5000;        // cycles without any beat
   localparam int PHASE_LEN = 150;

   // one expected peak report
   typedef struct {
      logic [POSITION_WIDTH-1:0] position;
      logic signed [SAMPLE_W-1:0] amplitude;
      logic [INDEX_W-1:0]         end_index;
   } peak_report_type;

   // DUT ports
   logic                               clock;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic signed [SAMPLE_W-1:0]         req_sample = '0;
   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic signed [THRESHOLD_WIDTH-1:0]  csr_amplitude_threshold = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic [POSITION_WIDTH-1:0]          rsp_peak_position;
   logic signed [SAMPLE_W-1:0]         rsp_peak_amplitude;
   logic [INDEX_W-1:0]                 rsp_end_index;

   // detector state as the predictor sees it
   logic signed [THRESHOLD_WIDTH-1:0]  det_threshold = '0;
   logic signed [SAMPLE_W-1:0]         recent_window [WIN];
   logic [POSITION_WIDTH-1:0]          sample_number = '0;
   bit                                 spike_on = 1'b0;
   bit                                 blocked = 1'b0;
   int                                 spike_len = 0;

   // stimulus and scoreboard
   logic signed [SAMPLE_W-1:0]         pending_samples [$];
   peak_report_type                    peak_reports [$];
   peak_report_type                    oldest_report;
   int                                 samples_queued = 0;
   int                                 samples_taken = 0;
   int                                 mismatches = 0;
   int                                 send_gap = 0;
   int                                 stall_left = 0;
   int                                 hold_requests = 0;
   int                                 hold_served = 0;
   int                                 stuck_cycles = 0;
   bit                                 sender_idles = 1'b1;
   bit                                 receiver_idles = 1'b1;
   int                                 phase_thr [$];
   int                                 p;

   spike_detect_peak_align i_dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_sample              (req_sample),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_amplitude_threshold (csr_amplitude_threshold),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_peak_position       (rsp_peak_position),
      .rsp_peak_amplitude      (rsp_peak_amplitude),
      .rsp_end_index           (rsp_end_index)
   );

   // clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // gap lengths: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // predictor: one accepted sample, at most one peak report
   function automatic void detect_spike(logic signed [SAMPLE_W-1:0] s);
      peak_report_type            rpt;
      logic signed [SAMPLE_W-1:0] min_val;
      logic [POSITION_WIDTH-1:0]  now;
      int                         age;
      int                         i;
      now = sample_number;
      for (i = WIN - 1; i > 0; i--) recent_window[i] = recent_window[i-1];
      recent_window[0] = s;
      sample_number = now + 1;
      if (det_threshold == 0) return;
      if (s < det_threshold && !blocked && !spike_on) spike_on = 1'b1;
      if (spike_on) begin
         spike_len++;
         // too long: drop it and block until the signal comes back up
         if (spike_len > WIN) begin
            spike_len = 0;
            spike_on  = 1'b0;
            blocked   = 1'b1;
         end
      end
      if (s > det_threshold && blocked) blocked = 1'b0;
      if (s > det_threshold && spike_on) begin
         spike_on  = 1'b0;
         spike_len = 0;
         min_val   = recent_window[0];
         age       = 0;
         // strict compare from newest to oldest: the newest minimum wins
         for (i = 1; i < WIN; i++) begin
            if (recent_window[i] < min_val) begin
               min_val = recent_window[i];
               age     = i;
            end
         end
         rpt.position  = now - POSITION_WIDTH'(age);
         rpt.amplitude = min_val;
         rpt.end_index = INDEX_W'((longint'(rpt.position) % DEPTH + OFFSET) % DEPTH);
         peak_reports.push_back(rpt);
      end
   endfunction

   // sample driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            detect_spike(req_sample);
            samples_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               req_valid <= 1'b0;
               send_gap--;
            end else if (pending_samples.size() > 0) begin
               req_valid  <= 1'b1;
               req_sample <= pending_samples.pop_front();
               send_gap = sender_idles ? pick_gap() : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (peak_reports.size() == 0) begin
               $display("%0t: unexpected peak report: position %h amplitude %0d index %h",
                        $time, rsp_peak_position, rsp_peak_amplitude, rsp_end_index);
               mismatches++;
            end else begin
               oldest_report = peak_reports.pop_front();
               if (rsp_peak_position !== oldest_report.position) begin
                  $display("%0t: peak_position expected %h actual %h",
                           $time, oldest_report.position, rsp_peak_position);
                  mismatches++;
               end
               if (rsp_peak_amplitude !== oldest_report.amplitude) begin
                  $display("%0t: peak_amplitude expected %0d actual %0d",
                           $time, oldest_report.amplitude, rsp_peak_amplitude);
                  mismatches++;
               end
               if (rsp_end_index !== oldest_report.end_index) begin
                  $display("%0t: end_index expected %h actual %h",
                           $time, oldest_report.end_index, rsp_end_index);
                  mismatches++;
               end
            end
         end
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            stall_left  = HOLD_OFF;
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            if (receiver_idles) stall_left = pick_gap();
         end
      end
   end

   // watchdog: no beat on any channel for too long
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            stuck_cycles = 0;
         else
            stuck_cycles++;
         if (stuck_cycles >= STUCK_MAX) begin
            $display("%0t: no progress for %0d cycles", $time, STUCK_MAX);
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   task automatic push_sample(input int v, inout int made);
      pending_samples.push_back(SAMPLE_W'(v));
      samples_queued++;
      made++;
   endtask

   // a sample strictly above the threshold, where one exists
   function automatic int above_thr(int thr);
      if (thr >= 32767) return $urandom_range(0, 65535) - 32768;
      if ($urandom_range(0, 4) == 0) return thr + 1 + $urandom_range(0, 32766 - thr);
      return thr + 1 + $urandom_range(0, (32766 - thr) < 2000 ? (32766 - thr) : 2000);
   endfunction

   // a sample strictly below the threshold, where one exists
   function automatic int below_thr(int thr);
      if (thr <= -32768) return $urandom_range(0, 65535) - 32768;
      if ($urandom_range(0, 4) == 0) return thr - 1 - $urandom_range(0, thr + 32767);
      return thr - 1 - $urandom_range(0, (thr + 32767) < 3000 ? (thr + 32767) : 3000);
   endfunction

   // spike trains with random content, plus some plain noise
   task automatic queue_spike_trains(input int thr, input int count);
      int made;
      int len;
      int k;
      made = 0;
      while (made < count) begin
         if ($urandom_range(0, 99) < 15) begin
            push_sample($urandom_range(0, 65535) - 32768, made);
         end else begin
            repeat ($urandom_range(0, 4)) push_sample(above_thr(thr), made);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(WIN + 1, WIN + 8)
                                               : $urandom_range(1, WIN);
            push_sample(below_thr(thr), made);
            for (k = 1; k < len; k++)
               push_sample(($urandom_range(0, 9) == 0) ? thr : below_thr(thr), made);
            if ($urandom_range(0, 9) == 0) push_sample(thr, made);
            push_sample(above_thr(thr), made);
         end
      end
   endtask

   // wait until every sample is taken and every report has come back
   task automatic wait_drained();
      while (samples_taken != samples_queued || peak_reports.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_threshold(input int thr);
      @(posedge clock);
      csr_valid               <= 1'b1;
      csr_amplitude_threshold <= THRESHOLD_WIDTH'(thr);
      do @(posedge clock); while (!csr_ready);
      csr_valid     <= 1'b0;
      det_threshold = THRESHOLD_WIDTH'(thr);
   endtask

   // sequence of phases
   initial begin
      int made;
      made = 0;
      foreach (recent_window[i]) recent_window[i] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // early window: reset zeros are the minimum, position wraps below zero
      write_threshold(100);
      push_sample(50, made);
      push_sample(200, made);
      wait_drained();

      // field extremes and samples equal to the threshold
      write_threshold(-1000);
      push_sample(-32768, made);
      push_sample(32767, made);
      push_sample(-1001, made);
      push_sample(-1000, made);
      push_sample(-999, made);
      push_sample(-1500, made);
      wait_drained();

      // detection disabled in mid-spike: samples counted, flags frozen
      write_threshold(0);
      push_sample(-5, made);
      push_sample(7, made);
      push_sample(-32768, made);
      wait_drained();
      write_threshold(-1000);
      push_sample(100, made);
      wait_drained();

      // random phases over a spread of thresholds
      phase_thr = '{-1000, -32768, 32767, 0, -1, 1, -20000, -300};
      phase_thr.push_back(-1 - $urandom_range(0, 32767));
      phase_thr.push_back(1 + $urandom_range(0, 32766));
      phase_thr.push_back($urandom_range(0, 65535) - 32768);
      for (p = 0; p < phase_thr.size(); p++) begin
         sender_idles   = (p % 4) != 3;
         receiver_idles = (p % 3) != 2;
         write_threshold(phase_thr[p]);
         if (phase_thr[p] == -20000) begin
            // receiver holds off while the sender keeps offering samples
            sender_idles = 1'b0;
            hold_requests <= hold_requests + 1;
         end
         queue_spike_trains(phase_thr[p], PHASE_LEN);
         wait_drained();
      end

      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* spike_detect_peak_align.f */
+incdir+rtl/core
rtl/core/sdpa_pkg.sv
rtl/core/sdpa_cell.sv
rtl/core/sdpa_ctrl.sv
rtl/core/spike_detect_peak_align.sv
test/spike_detect_peak_align_tb.sv
